FILE: design/tcp_session_state_tracker_assert.svh
// Assertion macros for the TCP session state tracker checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TCP_SESSION_STATE_TRACKER_ASSERT_SVH
`define TCP_SESSION_STATE_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TCPST_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TCPST_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tcpst_pkg.sv
// Shared types, codes and lookup functions for the TCP session state tracker.
// No dependencies; used by the interfaces, the top level and the checker.
package tcpst_pkg;

    localparam int OP_W    = 2;
    localparam int FLAGS_W = 5;
    localparam int STATE_W = 4;

    typedef logic [OP_W-1:0]    tcp_op_t;
    typedef logic [FLAGS_W-1:0] seg_flags_t;
    typedef logic [STATE_W-1:0] tcp_state_t;

    localparam tcp_op_t OP_SEGMENT  = 2'd0;
    localparam tcp_op_t OP_SENT_RST = 2'd1;
    localparam tcp_op_t OP_SENT_FIN = 2'd2;
    localparam tcp_op_t OP_TIMEOUT  = 2'd3;

    localparam int FLAG_FIN = 0;
    localparam int FLAG_SYN = 1;
    localparam int FLAG_RST = 2;
    localparam int FLAG_PSH = 3;
    localparam int FLAG_ACK = 4;

    localparam tcp_state_t ST_CLOSED      = 4'd0;
    localparam tcp_state_t ST_SYN_SENT    = 4'd2;
    localparam tcp_state_t ST_ESTABLISHED = 4'd4;
    localparam tcp_state_t ST_CLOSE_WAIT  = 4'd5;
    localparam tcp_state_t ST_FIN_WAIT_1  = 4'd7;
    localparam tcp_state_t ST_FIN_WAIT_2  = 4'd8;
    localparam tcp_state_t ST_CLOSING     = 4'd9;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_OPEN,
        EV_RECV_RST,
        EV_RECV_ACK,
        EV_RECV_FIN,
        EV_SENT_RST,
        EV_SENT_FIN,
        EV_TIMEOUT
    } tcp_event_t;

    // Segment decode: SYN, RST, then ACK or FIN; ACK with PSH gives no event.
    function automatic tcp_event_t decode_segment(input seg_flags_t fl);
        tcp_event_t ev;
        if (fl[FLAG_SYN])
        begin
            ev = EV_OPEN;
        end
        else if (fl[FLAG_RST])
        begin
            ev = EV_RECV_RST;
        end
        else if (fl[FLAG_ACK])
        begin
            if (fl[FLAG_PSH])
            begin
                ev = EV_NONE;
            end
            else if (fl[FLAG_FIN])
            begin
                ev = EV_RECV_FIN;
            end
            else
            begin
                ev = EV_RECV_ACK;
            end
        end
        else if (fl[FLAG_FIN])
        begin
            ev = EV_RECV_FIN;
        end
        else
        begin
            ev = EV_NONE;
        end
        return ev;
    endfunction

    function automatic tcp_state_t next_state(input tcp_state_t st, input tcp_event_t ev);
        tcp_state_t nxt;
        logic       any_rst;
        any_rst = (ev == EV_RECV_RST) || (ev == EV_SENT_RST);
        nxt     = st;
        case (st)
            ST_CLOSED:
            begin
                if (ev == EV_OPEN)
                begin
                    nxt = ST_SYN_SENT;
                end
            end
            ST_SYN_SENT:
            begin
                if (ev == EV_RECV_RST)
                begin
                    nxt = ST_CLOSED;
                end
                else if (ev == EV_RECV_ACK)
                begin
                    nxt = ST_ESTABLISHED;
                end
            end
            ST_ESTABLISHED:
            begin
                if (any_rst)
                begin
                    nxt = ST_CLOSED;
                end
                else if (ev == EV_RECV_FIN)
                begin
                    nxt = ST_CLOSE_WAIT;
                end
                else if (ev == EV_SENT_FIN)
                begin
                    nxt = ST_FIN_WAIT_1;
                end
            end
            ST_CLOSE_WAIT:
            begin
                if (any_rst || ev == EV_TIMEOUT || ev == EV_RECV_ACK)
                begin
                    nxt = ST_CLOSED;
                end
            end
            ST_FIN_WAIT_1:
            begin
                if (any_rst || ev == EV_TIMEOUT || ev == EV_RECV_FIN)
                begin
                    nxt = ST_CLOSED;
                end
                else if (ev == EV_RECV_ACK)
                begin
                    nxt = ST_FIN_WAIT_2;
                end
            end
            ST_FIN_WAIT_2:
            begin
                if (any_rst || ev == EV_TIMEOUT || ev == EV_RECV_FIN)
                begin
                    nxt = ST_CLOSED;
                end
            end
            ST_CLOSING:
            begin
                if (ev == EV_TIMEOUT || ev == EV_RECV_ACK)
                begin
                    nxt = ST_CLOSED;
                end
            end
            default:
            begin
                nxt = st;
            end
        endcase
        return nxt;
    endfunction

endpackage

FILE: design/tcpst_if.sv
// Valid/ready channel interfaces for event input and result output.
// Depends on tcpst_pkg for field types.
interface tcpst_in_if import tcpst_pkg::*;;
    logic       valid;
    logic       ready;
    tcp_op_t    op;
    seg_flags_t seg_flags;

    modport source (output valid, output op, output seg_flags, input ready);
    modport sink   (input valid, input op, input seg_flags, output ready);
endinterface

interface tcpst_out_if import tcpst_pkg::*;;
    logic       valid;
    logic       ready;
    tcp_state_t new_state;
    tcp_state_t previous_state;
    logic       state_changed;
    logic       bad_segment;

    modport source (output valid, output new_state, output previous_state,
                    output state_changed, output bad_segment, input ready);
    modport sink   (input valid, input new_state, input previous_state,
                    input state_changed, input bad_segment, output ready);
endinterface

FILE: design/tcp_session_state_tracker.sv
// The tracker takes one event transfer per clock cycle while the output is not
// stalled and returns one result transfer for each. An input register holds the
// event, the transition lookup runs combinationally on it and the session state,
// and a result register holds the answer; the session state advances as each
// event moves into the result register.
// Reset puts the session in CLOSED.
// Depends on tcpst_pkg and the channel interfaces in tcpst_if.sv.
module tcp_session_state_tracker
    import tcpst_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    tcpst_in_if.sink    in_ch,
    tcpst_out_if.source out_ch
);

    logic       in_valid_reg;
    tcp_op_t    op_reg;
    seg_flags_t flags_reg;

    logic       out_valid_reg;
    tcp_state_t new_state_reg;
    tcp_state_t prev_state_reg;
    logic       changed_reg;
    logic       bad_reg;

    tcp_state_t session_state_reg;
    tcp_state_t session_state_next;

    tcp_event_t ev;
    logic       bad_next;
    logic       out_load;
    logic       advance;

    assign out_load    = !out_valid_reg || out_ch.ready;
    assign advance     = in_valid_reg && out_load;
    assign in_ch.ready = !in_valid_reg || out_load;

    always_comb
    begin
        bad_next = 1'b0;
        case (op_reg)
            OP_SEGMENT:
            begin
                ev       = decode_segment(flags_reg);
                bad_next = !(flags_reg[FLAG_SYN] || flags_reg[FLAG_RST]
                             || flags_reg[FLAG_ACK] || flags_reg[FLAG_FIN]);
            end
            OP_SENT_RST: ev = EV_SENT_RST;
            OP_SENT_FIN: ev = EV_SENT_FIN;
            default:     ev = EV_TIMEOUT;
        endcase
        session_state_next = next_state(session_state_reg, ev);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            session_state_reg <= ST_CLOSED;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                session_state_reg <= session_state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            op_reg    <= in_ch.op;
            flags_reg <= in_ch.seg_flags;
        end
        if (advance)
        begin
            new_state_reg  <= session_state_next;
            prev_state_reg <= session_state_reg;
            changed_reg    <= session_state_next != session_state_reg;
            bad_reg        <= bad_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.new_state      = new_state_reg;
    assign out_ch.previous_state = prev_state_reg;
    assign out_ch.state_changed  = changed_reg;
    assign out_ch.bad_segment    = bad_reg;

endmodule

FILE: design/tcpst_checker.sv
// Port-level checker for the TCP session state tracker, bound to the top level.
// Depends on tcpst_pkg and tcp_session_state_tracker_assert.svh.
`include "tcp_session_state_tracker_assert.svh"

module tcpst_checker
    import tcpst_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input tcp_state_t new_state,
    input tcp_state_t previous_state,
    input logic       state_changed,
    input logic       bad_segment
);

    tcp_state_t last_state_reg;
    logic       out_xfer;

    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_state_reg <= ST_CLOSED;
        end
        else if (out_xfer)
        begin
            last_state_reg <= new_state;
        end
    end

    `TCPST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(new_state) && $stable(previous_state), "result changed while stalled")
    `TCPST_ASSERT_NOW(a_chain, out_xfer, previous_state == last_state_reg, "previous state does not follow the last result")
    `TCPST_ASSERT_NOW(a_changed, out_valid, state_changed == (new_state != previous_state), "changed flag disagrees with states")
    `TCPST_ASSERT_NOW(a_bad_keeps, out_valid && bad_segment, !state_changed, "bad segment changed the state")
    `TCPST_ASSERT_NOW(a_reachable, out_valid, new_state == ST_CLOSED || new_state == ST_SYN_SENT || new_state == ST_ESTABLISHED || new_state == ST_CLOSE_WAIT || new_state == ST_FIN_WAIT_1 || new_state == ST_FIN_WAIT_2 || new_state == ST_CLOSING, "unreachable state reported")

endmodule

bind tcp_session_state_tracker tcpst_checker u_tcpst_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .new_state      (out_ch.new_state),
    .previous_state (out_ch.previous_state),
    .state_changed  (out_ch.state_changed),
    .bad_segment    (out_ch.bad_segment)
);

FILE: tb/sv/tb_tcp_session_state_tracker.sv
`timescale 1ns / 100ps
// Self-checking testbench for tcp_session_state_tracker: a table of directed events,
// then steered random event sequences under several idling phases.
// Depends on tcpst_pkg and the channel interfaces in tcpst_if.sv.
module tb_tcp_session_state_tracker;
    import tcpst_pkg::*;

    localparam int RANDOM_PER_PHASE = 150;
    localparam int HOLD_CYCLES      = 64;
    localparam int STALL_LIMIT      = 4000;

    typedef struct packed {
        tcp_op_t    op;
        seg_flags_t flags;
    } event_item_t;

    typedef struct packed {
        tcp_state_t new_state;
        tcp_state_t previous_state;
        logic       state_changed;
        logic       bad_segment;
    } session_result_t;

    typedef struct packed {
        event_item_t     item;
        logic            typed;
        session_result_t want;
    } event_row_t;

    typedef enum int {
        PH_STEADY,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH_IDLE
    } idle_phase_t;

    logic clk;
    logic rst_n;

    tcpst_in_if  in_ch ();
    tcpst_out_if out_ch ();

    tcp_session_state_tracker u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    int unsigned     send_idle_pct [4] = '{0, 59, 0, 26};
    int unsigned     recv_stall_pct [4] = '{0, 0, 59, 26};
    idle_phase_t     phase = PH_STEADY;
    bit              hold_request = 1'b0;
    bit              hold_done = 1'b0;
    tcp_state_t      tracked_state = ST_CLOSED;
    session_result_t pending_transitions [$];
    event_row_t      event_table [$];
    int              mismatches = 0;
    int              results_seen = 0;
    int              quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic session_result_t predict_transition(input tcp_state_t cur,
                                                           input event_item_t item);
        session_result_t r;
        tcp_event_t      ev;
        logic            any_reset;
        r.bad_segment = 1'b0;
        case (item.op)
            OP_SEGMENT:
            begin
                if (item.flags[FLAG_SYN])
                begin
                    ev = EV_OPEN;
                end
                else if (item.flags[FLAG_RST])
                begin
                    ev = EV_RECV_RST;
                end
                else if (item.flags[FLAG_ACK])
                begin
                    ev = item.flags[FLAG_PSH] ? EV_NONE
                       : (item.flags[FLAG_FIN] ? EV_RECV_FIN : EV_RECV_ACK);
                end
                else if (item.flags[FLAG_FIN])
                begin
                    ev = EV_RECV_FIN;
                end
                else
                begin
                    ev = EV_NONE;
                    r.bad_segment = 1'b1;
                end
            end
            OP_SENT_RST:
            begin
                ev = EV_SENT_RST;
            end
            OP_SENT_FIN:
            begin
                ev = EV_SENT_FIN;
            end
            default:
            begin
                ev = EV_TIMEOUT;
            end
        endcase
        any_reset = (ev == EV_RECV_RST) || (ev == EV_SENT_RST);
        r.new_state = cur;
        case (cur)
            ST_CLOSED:
            begin
                if (ev == EV_OPEN)
                begin
                    r.new_state = ST_SYN_SENT;
                end
            end
            ST_SYN_SENT:
            begin
                if (ev == EV_RECV_RST)
                begin
                    r.new_state = ST_CLOSED;
                end
                else if (ev == EV_RECV_ACK)
                begin
                    r.new_state = ST_ESTABLISHED;
                end
            end
            ST_ESTABLISHED:
            begin
                if (any_reset)
                begin
                    r.new_state = ST_CLOSED;
                end
                else if (ev == EV_RECV_FIN)
                begin
                    r.new_state = ST_CLOSE_WAIT;
                end
                else if (ev == EV_SENT_FIN)
                begin
                    r.new_state = ST_FIN_WAIT_1;
                end
            end
            ST_CLOSE_WAIT:
            begin
                if (any_reset || ev == EV_TIMEOUT || ev == EV_RECV_ACK)
                begin
                    r.new_state = ST_CLOSED;
                end
            end
            ST_FIN_WAIT_1:
            begin
                if (any_reset || ev == EV_TIMEOUT || ev == EV_RECV_FIN)
                begin
                    r.new_state = ST_CLOSED;
                end
                else if (ev == EV_RECV_ACK)
                begin
                    r.new_state = ST_FIN_WAIT_2;
                end
            end
            ST_FIN_WAIT_2:
            begin
                if (any_reset || ev == EV_TIMEOUT || ev == EV_RECV_FIN)
                begin
                    r.new_state = ST_CLOSED;
                end
            end
            ST_CLOSING:
            begin
                if (ev == EV_TIMEOUT || ev == EV_RECV_ACK)
                begin
                    r.new_state = ST_CLOSED;
                end
            end
            default:
            begin
                r.new_state = cur;
            end
        endcase
        r.previous_state = cur;
        r.state_changed  = (r.new_state != cur);
        return r;
    endfunction

    function automatic event_item_t shape_event(input tcp_event_t ev);
        event_item_t item;
        item.op    = OP_SEGMENT;
        item.flags = seg_flags_t'($urandom_range(31));
        case (ev)
            EV_OPEN:
            begin
                item.flags[FLAG_SYN] = 1'b1;
            end
            EV_RECV_RST:
            begin
                item.flags[FLAG_SYN] = 1'b0;
                item.flags[FLAG_RST] = 1'b1;
            end
            EV_RECV_ACK:
            begin
                item.flags[FLAG_SYN] = 1'b0;
                item.flags[FLAG_RST] = 1'b0;
                item.flags[FLAG_ACK] = 1'b1;
                item.flags[FLAG_PSH] = 1'b0;
                item.flags[FLAG_FIN] = 1'b0;
            end
            EV_RECV_FIN:
            begin
                item.flags[FLAG_SYN] = 1'b0;
                item.flags[FLAG_RST] = 1'b0;
                item.flags[FLAG_FIN] = 1'b1;
                if (item.flags[FLAG_ACK])
                begin
                    item.flags[FLAG_PSH] = 1'b0;
                end
            end
            EV_SENT_RST:
            begin
                item.op = OP_SENT_RST;
            end
            EV_SENT_FIN:
            begin
                item.op = OP_SENT_FIN;
            end
            EV_TIMEOUT:
            begin
                item.op = OP_TIMEOUT;
            end
            default:
            begin
                // Either a pushed data segment, which is ignored, or one with no usable flag.
                item.flags[FLAG_SYN] = 1'b0;
                item.flags[FLAG_RST] = 1'b0;
                if ($urandom_range(1) == 1)
                begin
                    item.flags[FLAG_ACK] = 1'b1;
                    item.flags[FLAG_PSH] = 1'b1;
                end
                else
                begin
                    item.flags[FLAG_ACK] = 1'b0;
                    item.flags[FLAG_FIN] = 1'b0;
                end
            end
        endcase
        return item;
    endfunction

    // Most events are chosen to move the session on, so that the deeper states are visited.
    function automatic event_item_t next_random_item(input tcp_state_t cur);
        event_item_t     item;
        session_result_t trial;
        int unsigned     roll;
        roll = $urandom_range(99);
        if (roll < 12)
        begin
            item.op    = tcp_op_t'($urandom_range(3));
            item.flags = seg_flags_t'($urandom_range(31));
            return item;
        end
        item = shape_event(tcp_event_t'($urandom_range(7)));
        if (roll < 35)
        begin
            return item;
        end
        for (int k = 0; k < 8; k++)
        begin
            trial = predict_transition(cur, item);
            if (trial.state_changed)
            begin
                break;
            end
            item = shape_event(tcp_event_t'($urandom_range(7)));
        end
        return item;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task automatic add_row(input tcp_op_t op, input seg_flags_t flags, input logic typed,
                           input tcp_state_t ns, input tcp_state_t ps,
                           input logic changed, input logic bad);
        event_row_t row;
        row.item.op              = op;
        row.item.flags           = flags;
        row.typed                = typed;
        row.want.new_state       = ns;
        row.want.previous_state  = ps;
        row.want.state_changed   = changed;
        row.want.bad_segment     = bad;
        event_table.push_back(row);
    endtask

    task automatic send_event(input event_item_t item, input logic typed,
                              input session_result_t typed_want);
        int              gap;
        session_result_t predicted;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct[phase])
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= item.op;
        in_ch.seg_flags <= item.flags;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        predicted     = predict_transition(tracked_state, item);
        tracked_state = predicted.new_state;
        pending_transitions.push_back(typed ? typed_want : predicted);
    endtask

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct[phase]);
            end
        end
    end

    always @(posedge clk)
    begin
        session_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (pending_transitions.size() == 0)
            begin
                report_mismatch($sformatf("result with no event waiting, new_state %0d",
                                          out_ch.new_state));
            end
            else
            begin
                want = pending_transitions.pop_front();
                if (out_ch.new_state !== want.new_state)
                begin
                    report_mismatch($sformatf("new_state %0d, expected %0d",
                                              out_ch.new_state, want.new_state));
                end
                if (out_ch.previous_state !== want.previous_state)
                begin
                    report_mismatch($sformatf("previous_state %0d, expected %0d",
                                              out_ch.previous_state, want.previous_state));
                end
                if (out_ch.state_changed !== want.state_changed)
                begin
                    report_mismatch($sformatf("state_changed %0b, expected %0b",
                                              out_ch.state_changed, want.state_changed));
                end
                if (out_ch.bad_segment !== want.bad_segment)
                begin
                    report_mismatch($sformatf("bad_segment %0b, expected %0b",
                                              out_ch.bad_segment, want.bad_segment));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        session_result_t blank;
        event_item_t     item;
        blank           = '0;
        rst_n           = 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.op        <= OP_SEGMENT;
        in_ch.seg_flags <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(OP_SEGMENT,  5'b00000, 1'b1, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b1);
        add_row(OP_SEGMENT,  5'b01000, 1'b1, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b1);
        add_row(OP_SENT_RST, 5'b11111, 1'b1, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_TIMEOUT,  5'b11111, 1'b1, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SENT_FIN, 5'b00000, 1'b1, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SEGMENT,  5'b11111, 1'b1, ST_SYN_SENT, ST_CLOSED, 1'b1, 1'b0);
        add_row(OP_SEGMENT,  5'b10000, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SEGMENT,  5'b11000, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SEGMENT,  5'b00100, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SEGMENT,  5'b00010, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SEGMENT,  5'b00100, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SEGMENT,  5'b00010, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SEGMENT,  5'b10000, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SEGMENT,  5'b10001, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_TIMEOUT,  5'b00000, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SEGMENT,  5'b00010, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SEGMENT,  5'b10000, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SENT_FIN, 5'b00000, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SEGMENT,  5'b10000, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SEGMENT,  5'b00001, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SEGMENT,  5'b10010, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SEGMENT,  5'b10000, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SENT_RST, 5'b00000, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);
        add_row(OP_SEGMENT,  5'b01001, 1'b0, ST_CLOSED,   ST_CLOSED, 1'b0, 1'b0);

        foreach (event_table[i])
        begin
            send_event(event_table[i].item, event_table[i].typed, event_table[i].want);
        end

        for (int p = 0; p < 4; p++)
        begin
            phase = idle_phase_t'(p);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // The output is held off for a long stretch while the sender keeps offering events.
                if (phase == PH_STEADY && n == 40)
                begin
                    hold_request = 1'b1;
                end
                item = next_random_item(tracked_state);
                send_event(item, 1'b0, blank);
            end
        end
        in_ch.valid <= 1'b0;

        while (pending_transitions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
